/* sv/krt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types, codes and helpers for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int SLOTS      = 128;
  localparam int ADDR_W     = $clog2(SLOTS);
  localparam int SLOT_W     = 7;
  localparam int KEY_BYTES  = 19;
  localparam int KEY_W      = 8 * KEY_BYTES;
  localparam int VALUE_W    = 72;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_DELETE = 2'd2
  } req_kind_t;

  typedef enum logic [2:0] {
    OUT_INSERTED  = 3'd0,
    OUT_FULL      = 3'd1,
    OUT_FOUND     = 3'd2,
    OUT_NOT_FOUND = 3'd3,
    OUT_DELETED   = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [7:0]  value_hi;
    logic [63:0] value_lo;
    logic [23:0] second_c;
    logic [63:0] second_b;
    logic [63:0] second_a;
    logic [23:0] first_c;
    logic [63:0] first_b;
    logic [63:0] first_a;
  } record_t;

  localparam int REC_W = $bits(record_t);

  typedef struct packed {
    logic [1:0] kind;
    record_t    rec;
  } request_t;

  typedef struct packed {
    logic        done;
    outcome_t    outcome;
    logic [SLOT_W-1:0] slot;
    logic [63:0] found_lo;
    logic [7:0]  found_hi;
  } result_t;

  // Zero every byte after the first zero byte; byte 0 sits in bits 7:0.
  function automatic logic [KEY_W-1:0] trim_str(input logic [KEY_W-1:0] s);
    logic             ended;
    logic [KEY_W-1:0] r;
    ended = 1'b0;
    r     = s;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (ended) begin
        r[8*i +: 8] = 8'd0;
      end else if (s[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

/* sv/krt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/krt_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_scan
// Scan sequencer: walks the table one slot per cycle, matches, writes back.
// ----------------------------------------------------------------------------
module krt_scan (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  krt_pkg::request_t        req,
  output logic                     busy,
  output logic                     ram_we,
  output logic [krt_pkg::ADDR_W-1:0] ram_waddr,
  output logic                     ram_re,
  output logic [krt_pkg::ADDR_W-1:0] ram_raddr,
  input  logic [krt_pkg::REC_W-1:0]  ram_rdata,
  output krt_pkg::result_t         res
);
  import krt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(SLOTS - 1);

  state_t            state;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cmp_addr;
  logic              cmp_vld;
  logic              valid_q;
  logic [SLOTS-1:0]  valid;

  record_t ent;
  logic    first_zero;
  logic    keys_eq;
  logic    hit;
  logic    finish;

  // Slots never written since reset read as all zero.
  always_comb begin
    ent        = valid_q ? record_t'(ram_rdata) : '0;
    first_zero = (ent.first_a == 64'd0) && (ent.first_b == 64'd0) &&
                 (ent.first_c == 24'd0);
    keys_eq    = (ent.first_a == req.rec.first_a) &&
                 (ent.first_b == req.rec.first_b) &&
                 (ent.first_c == req.rec.first_c) &&
                 (ent.second_a == req.rec.second_a) &&
                 (ent.second_b == req.rec.second_b) &&
                 (ent.second_c == req.rec.second_c);
    case (req.kind)
      REQ_INSERT: hit = first_zero;
      REQ_LOOKUP, REQ_DELETE: hit = keys_eq;
      default:    hit = 1'b0;
    endcase
    finish = (state == S_SCAN) && cmp_vld && (hit || (cmp_addr == LAST));
  end

  assign busy      = (state != S_IDLE);
  assign ram_re    = (state == S_SCAN);
  assign ram_raddr = rd_addr;
  assign ram_we    = finish && hit && (req.kind == REQ_INSERT);
  assign ram_waddr = cmp_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cmp_vld  <= 1'b0;
      valid    <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= finish;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            state   <= S_SCAN;
            rd_addr <= '0;
            cmp_vld <= 1'b0;
          end
        end
        S_SCAN: begin
          cmp_addr <= rd_addr;
          cmp_vld  <= 1'b1;
          valid_q  <= valid[rd_addr];
          // hold at the last slot so the read never runs past the table
          if (rd_addr != LAST) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (finish) begin
            state <= S_IDLE;
            if (hit && (req.kind == REQ_INSERT)) begin
              valid[cmp_addr] <= 1'b1;
            end
            if (hit && (req.kind == REQ_DELETE)) begin
              valid[cmp_addr] <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // Result payload.
      if (finish) begin
        res.slot     <= hit ? SLOT_W'(cmp_addr) : '0;
        res.found_lo <= (hit && (req.kind == REQ_LOOKUP)) ? ent.value_lo : 64'd0;
        res.found_hi <= (hit && (req.kind == REQ_LOOKUP)) ? ent.value_hi : 8'd0;
        case (req.kind)
          REQ_INSERT: res.outcome <= hit ? OUT_INSERTED : OUT_FULL;
          REQ_LOOKUP: res.outcome <= hit ? OUT_FOUND : OUT_NOT_FOUND;
          REQ_DELETE: res.outcome <= hit ? OUT_DELETED : OUT_NOT_FOUND;
          default:    res.outcome <= OUT_NOT_FOUND;
        endcase
      end
    end
  end

endmodule

/* sv/keyed_record_table_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Linear-search table of records keyed by first name and surname.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// while the sequencer reads the record memory one slot per cycle, until the
// request stops at a matching slot or has scanned the whole table. Its single
// result shows on outcome, slot, found_lo and found_hi for exactly one cycle
// with done high, and cannot be held off. The table reads empty right after
// reset through a bank of per-slot valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
module keyed_record_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [63:0] first_key_a,
  input  logic [63:0] first_key_b,
  input  logic [23:0] first_key_c,
  input  logic [63:0] second_key_a,
  input  logic [63:0] second_key_b,
  input  logic [23:0] second_key_c,
  input  logic [63:0] value_lo,
  input  logic [7:0]  value_hi,
  output logic        done,
  output logic [2:0]  outcome,
  output logic [6:0]  slot,
  output logic [63:0] found_lo,
  output logic [7:0]  found_hi
);
  import krt_pkg::*;

  logic               go;
  logic [KEY_W-1:0]   first_t;
  logic [KEY_W-1:0]   second_t;
  logic [VALUE_W-1:0] value_t;
  request_t           req;
  result_t            res;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [REC_W-1:0]  ram_rdata;

  assign go = start && !busy;

  // Drop bytes past each terminator before storing or comparing.
  always_comb begin
    first_t  = trim_str({first_key_c, first_key_b, first_key_a});
    second_t = trim_str({second_key_c, second_key_b, second_key_a});
    value_t  = VALUE_W'(trim_str({(KEY_W - VALUE_W)'(0), value_hi, value_lo}));
  end

  always_ff @(posedge clk) begin
    if (go) begin
      req.kind         <= req_type;
      req.rec.first_a  <= first_t[63:0];
      req.rec.first_b  <= first_t[127:64];
      req.rec.first_c  <= first_t[151:128];
      req.rec.second_a <= second_t[63:0];
      req.rec.second_b <= second_t[127:64];
      req.rec.second_c <= second_t[151:128];
      req.rec.value_lo <= value_t[63:0];
      req.rec.value_hi <= value_t[71:64];
    end
  end

  krt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .req       (req),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (REC_W'(req.rec)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign done     = res.done;
  assign outcome  = res.outcome;
  assign slot     = res.slot;
  assign found_lo = res.found_lo;
  assign found_hi = res.found_hi;

endmodule
